### sv/triangle_region_classifier_macros.svh
// assertion macros shared by the triangle region classifier rtl
// expects clk and arst_n in the scope of each use
`ifndef TRIANGLE_REGION_CLASSIFIER_MACROS_SVH
`define TRIANGLE_REGION_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TRC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trc assertion failed");

// next-cycle implication, disabled while in reset
`define TRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trc assertion failed");

`endif

### sv/trc_pkg.sv
// shared constants and types for the triangle region classifier
// no dependencies
package trc_pkg;

	localparam int COORD_BITS_DEF = 21;
	localparam int CFG_IDX_BITS = 4;
	localparam int REGION_BITS = 2;
	localparam int NUM_REGIONS = 2;
	localparam int NUM_VERTS = 3;
	localparam int NUM_SIDES = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_APEX = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_APEX = 4'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM_POINT = 4'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOP_POINT = 4'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_CENTER = 4'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_CENTER = 4'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_RADIUS = 4'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_RADIUS = 4'd7;

	// opcodes
	localparam logic OP_REGION = 1'b0;
	localparam logic OP_SPHERE = 1'b1;

	// result codes
	localparam logic [REGION_BITS-1:0] REGION_NONE = 2'd0;
	localparam logic [REGION_BITS-1:0] REGION_LEFT = 2'd1;
	localparam logic [REGION_BITS-1:0] REGION_RIGHT = 2'd2;

	// sign of one triple product
	typedef struct packed {
		logic pos;
		logic neg;
	} trc_sign_t;

endpackage

### sv/trc_item_if.sv
// input channel carrying one triangle and its opcode
// depends on trc_pkg
interface trc_item_if #(parameter int COORD_BITS = trc_pkg::COORD_BITS_DEF);
	logic valid;
	logic ready;
	logic opcode;
	logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z;
	logic signed [COORD_BITS-1:0] v1_x, v1_y, v1_z;
	logic signed [COORD_BITS-1:0] v2_x, v2_y, v2_z;

	modport source (output valid, opcode, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, input ready);
	modport sink (input valid, opcode, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, output ready);
endinterface

### sv/trc_result_if.sv
// output channel carrying one region code
// depends on trc_pkg
interface trc_result_if;
	logic valid;
	logic ready;
	logic [trc_pkg::REGION_BITS-1:0] region;

	modport source (output valid, region, input ready);
	modport sink (input valid, region, output ready);
endinterface

### sv/trc_cfg_if.sv
// configuration write channel, register index plus data
// depends on trc_pkg
interface trc_cfg_if #(parameter int COORD_BITS = trc_pkg::COORD_BITS_DEF);
	logic valid;
	logic ready;
	logic [trc_pkg::CFG_IDX_BITS-1:0] index;
	logic [3*COORD_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/trc_cross.sv
// registered 3d cross product of two signed vectors
// no dependencies
module trc_cross #(
	parameter int IN_BITS = 22
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [2:0][IN_BITS-1:0]     a,
	input  logic [2:0][IN_BITS-1:0]     b,
	output logic [2:0][2*IN_BITS:0]     cross_s2
);
	localparam int P = 2 * IN_BITS;

	logic [2:0][P-1:0] pa;
	logic [2:0][P-1:0] pb;

	// component k takes a[k+1]*b[k+2] - a[k+2]*b[k+1]
	for (genvar k = 0; k < 3; k++) begin : g_comp
		assign pa[k] = $signed(a[(k + 1) % 3]) * $signed(b[(k + 2) % 3]);
		assign pb[k] = $signed(a[(k + 2) % 3]) * $signed(b[(k + 1) % 3]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				cross_s2[k] <= (P + 1)'($signed(pa[k])) - (P + 1)'($signed(pb[k]));
			end
		end
	end
endmodule

### sv/trc_side_lane.sv
// one same-side test: sign of (edge x (p - corner)) . n, pipelined
// depends on trc_pkg and trc_cross
module trc_side_lane #(
	parameter int COORD_BITS = trc_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [2:0][COORD_BITS:0]        edge_vec,
	input  logic [2:0][COORD_BITS:0]        corner,
	input  logic [2:0][COORD_BITS-1:0]      point_s1,
	input  logic [2:0][2*COORD_BITS+2:0]    norm_s2,
	output trc_pkg::trc_sign_t              sign_s5
);
	import trc_pkg::*;

	localparam int D = COORD_BITS + 1;
	localparam int X = 2 * D + 1;
	localparam int L = (X + 1) / 2;
	localparam int H = X - L;
	localparam int W = 2 * X + 2;

	logic [2:0][D-1:0] diff;
	logic [2:0][X-1:0] cross_s2;
	logic [2:0][2*H-1:0] hh_s3;
	logic [2:0][H+L:0] hl_s3;
	logic [2:0][H+L:0] lh_s3;
	logic [2:0][2*L-1:0] ll_s3;
	logic [W-1:0] hh_sum_s4;
	logic [W-1:0] mid_sum_s4;
	logic [W-1:0] ll_sum_s4;
	logic [W-1:0] total;

	// vertex relative to the edge start
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = D'($signed(point_s1[k])) - corner[k];
		end
	end

	trc_cross #(.IN_BITS(D)) u_cross (
		.clk      (clk),
		.en       (en),
		.a        (edge_vec),
		.b        (diff),
		.cross_s2 (cross_s2)
	);

	// split products of the dot product, high part signed, low part unsigned
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				hh_s3[k] <= $signed(cross_s2[k][X-1:L]) * $signed(norm_s2[k][X-1:L]);
				hl_s3[k] <= $signed(cross_s2[k][X-1:L]) * $signed({1'b0, norm_s2[k][L-1:0]});
				lh_s3[k] <= $signed({1'b0, cross_s2[k][L-1:0]}) * $signed(norm_s2[k][X-1:L]);
				ll_s3[k] <= cross_s2[k][L-1:0] * norm_s2[k][L-1:0];
			end
		end
	end

	// sum partial products of equal weight
	always_ff @(posedge clk) begin
		if (en) begin
			hh_sum_s4 <= W'($signed(hh_s3[0])) + W'($signed(hh_s3[1]))
				+ W'($signed(hh_s3[2]));
			mid_sum_s4 <= W'($signed(hl_s3[0])) + W'($signed(hl_s3[1]))
				+ W'($signed(hl_s3[2])) + W'($signed(lh_s3[0]))
				+ W'($signed(lh_s3[1])) + W'($signed(lh_s3[2]));
			ll_sum_s4 <= W'(ll_s3[0]) + W'(ll_s3[1]) + W'(ll_s3[2]);
		end
	end

	// recombine and keep only the sign
	assign total = (hh_sum_s4 << (2 * L)) + (mid_sum_s4 << L) + ll_sum_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s5.neg <= total[W-1];
			sign_s5.pos <= !total[W-1] && (|total);
		end
	end
endmodule

### sv/trc_sphere_lane.sv
// one vertex against one sphere: squared distance below squared radius
// depends on trc_pkg
module trc_sphere_lane #(
	parameter int COORD_BITS = trc_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [2:0][COORD_BITS-1:0]  point_s1,
	input  logic [2:0][COORD_BITS-1:0]  center,
	input  logic [COORD_BITS-2:0]       radius,
	output logic                        ok_s5
);
	localparam int D = COORD_BITS + 1;
	localparam int S = 2 * D;

	logic [2:0][D-1:0] diff;
	logic [2:0][S-1:0] sq_s2;
	logic [2*COORD_BITS-3:0] rsq_s2;
	logic ok_s3;
	logic ok_s4;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = D'($signed(point_s1[k])) - D'($signed(center[k]));
		end
	end

	// squares of each component and of the radius
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= $signed(diff[k]) * $signed(diff[k]);
			end
			rsq_s2 <= radius * radius;
		end
	end

	// sum and compare, then align with the side lanes
	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3 <= ((S + 2)'(sq_s2[0]) + (S + 2)'(sq_s2[1]) + (S + 2)'(sq_s2[2]))
				< (S + 2)'(rsq_s2);
			ok_s4 <= ok_s3;
			ok_s5 <= ok_s4;
		end
	end
endmodule

### sv/trc_merge.sv
// combines lane signs and sphere checks into the region code
// depends on trc_pkg
module trc_merge (
	input  logic                                 opcode,
	input  trc_pkg::trc_sign_t [trc_pkg::NUM_REGIONS-1:0][trc_pkg::NUM_VERTS-1:0]
		[trc_pkg::NUM_SIDES-1:0]                 signs,
	input  logic [trc_pkg::NUM_REGIONS-1:0][trc_pkg::NUM_VERTS-1:0] sphere_ok,
	output logic [trc_pkg::REGION_BITS-1:0]     region
);
	import trc_pkg::*;

	logic [NUM_REGIONS-1:0] hit;
	logic [NUM_REGIONS-1:0] ok;

	// a vertex is inside when all three side signs agree and are nonzero
	always_comb begin
		for (int r = 0; r < NUM_REGIONS; r++) begin
			hit[r] = 1'b1;
			ok[r] = &sphere_ok[r];
			for (int i = 0; i < NUM_VERTS; i++) begin
				hit[r] = hit[r] && ((signs[r][i][0].pos && signs[r][i][1].pos
					&& signs[r][i][2].pos) || (signs[r][i][0].neg
					&& signs[r][i][1].neg && signs[r][i][2].neg));
			end
		end
	end

	// left has priority, a left hit failing the sphere gives outside
	always_comb begin
		region = REGION_NONE;
		if (hit[0]) begin
			region = (opcode == OP_REGION || ok[0]) ? REGION_LEFT : REGION_NONE;
		end else if (hit[1]) begin
			region = (opcode == OP_REGION || ok[1]) ? REGION_RIGHT : REGION_NONE;
		end
	end
endmodule

### sv/triangle_region_classifier.sv
// An accepted transaction runs through stages s1 to s5 and then the output register.
// One triangle per cycle unless stalled; 18 side and 6 sphere lanes work in parallel.
// The pipeline stalls as a whole only while the output register holds an untaken result.
// Reset (arst_n low) clears the valid pipeline, the output valid and all config to zero.
// depends on trc_pkg, the channel interfaces, trc_cross, trc_side_lane,
// trc_sphere_lane and trc_merge
`include "triangle_region_classifier_macros.svh"

module triangle_region_classifier #(
	parameter int COORD_BITS = trc_pkg::COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	trc_cfg_if.sink             cfg,
	trc_item_if.sink            item,
	trc_result_if.source        result
);
	import trc_pkg::*;

	localparam int C = COORD_BITS;
	localparam int D = C + 1;
	localparam int X = 2 * D + 1;

	logic [3*C-1:0] left_apex_q, right_apex_q, bottom_q, top_q;
	logic [3*C-1:0] left_center_q, right_center_q;
	logic [C-2:0] left_radius_q, right_radius_q;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic op_s1, op_s2, op_s3, op_s4, op_s5;
	logic out_valid_q;
	logic [REGION_BITS-1:0] region_q;
	logic [REGION_BITS-1:0] region_next;

	logic [NUM_VERTS-1:0][2:0][C-1:0] p_s1;
	logic [NUM_REGIONS-1:0][2:0][2:0][D-1:0] corner;
	logic [NUM_REGIONS-1:0][2:0][2:0][D-1:0] edge_vec;
	logic [NUM_REGIONS-1:0][2:0][D-1:0] top_rel;
	logic [NUM_REGIONS-1:0][2:0][X-1:0] norm_s2;
	logic [NUM_REGIONS-1:0][2:0][C-1:0] center;
	logic [NUM_REGIONS-1:0][C-2:0] radius;
	trc_sign_t [NUM_REGIONS-1:0][NUM_VERTS-1:0][NUM_SIDES-1:0] sign_s5;
	logic [NUM_REGIONS-1:0][NUM_VERTS-1:0] ok_s5;
	logic [NUM_REGIONS*NUM_VERTS*NUM_SIDES-1:0] both_flags;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_apex_q <= '0;
			right_apex_q <= '0;
			bottom_q <= '0;
			top_q <= '0;
			left_center_q <= '0;
			right_center_q <= '0;
			left_radius_q <= '0;
			right_radius_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LEFT_APEX:    left_apex_q <= cfg.data;
				REG_RIGHT_APEX:   right_apex_q <= cfg.data;
				REG_BOTTOM_POINT: bottom_q <= cfg.data;
				REG_TOP_POINT:    top_q <= cfg.data;
				REG_LEFT_CENTER:  left_center_q <= cfg.data;
				REG_RIGHT_CENTER: right_center_q <= cfg.data;
				REG_LEFT_RADIUS:  left_radius_q <= cfg.data[C-2:0];
				REG_RIGHT_RADIUS: right_radius_q <= cfg.data[C-2:0];
				default: ;
			endcase
		end
	end

	// unpack region corners: apex, bottom, top; edges run corner s to s+1
	for (genvar k = 0; k < 3; k++) begin : g_unpack
		assign corner[0][0][k] = D'($signed(left_apex_q[C*k +: C]));
		assign corner[1][0][k] = D'($signed(right_apex_q[C*k +: C]));
		assign corner[0][1][k] = D'($signed(bottom_q[C*k +: C]));
		assign corner[1][1][k] = D'($signed(bottom_q[C*k +: C]));
		assign corner[0][2][k] = D'($signed(top_q[C*k +: C]));
		assign corner[1][2][k] = D'($signed(top_q[C*k +: C]));
		assign center[0][k] = left_center_q[C*k +: C];
		assign center[1][k] = right_center_q[C*k +: C];
	end

	assign radius[0] = left_radius_q;
	assign radius[1] = right_radius_q;

	for (genvar r = 0; r < NUM_REGIONS; r++) begin : g_edges
		for (genvar s = 0; s < 3; s++) begin : g_side
			for (genvar k = 0; k < 3; k++) begin : g_comp
				assign edge_vec[r][s][k] = corner[r][(s + 1) % 3][k] - corner[r][s][k];
			end
		end
		for (genvar k = 0; k < 3; k++) begin : g_top
			assign top_rel[r][k] = corner[r][2][k] - corner[r][0][k];
		end

		// region normal, aligned with the lane cross products
		trc_cross #(.IN_BITS(D)) u_norm (
			.clk      (clk),
			.en       (en),
			.a        (edge_vec[r][0]),
			.b        (top_rel[r]),
			.cross_s2 (norm_s2[r])
		);
	end

	// whole pipeline moves unless a result waits untaken
	assign en = !out_valid_q || result.ready;
	assign item.ready = en;

	// input stage
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= item.opcode;
			p_s1[0] <= {item.v0_z, item.v0_y, item.v0_x};
			p_s1[1] <= {item.v1_z, item.v1_y, item.v1_x};
			p_s1[2] <= {item.v2_z, item.v2_y, item.v2_x};
			op_s2 <= op_s1;
			op_s3 <= op_s2;
			op_s4 <= op_s3;
			op_s5 <= op_s4;
		end
	end

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// lanes: one per region, vertex and side, plus one sphere check per region and vertex
	for (genvar r = 0; r < NUM_REGIONS; r++) begin : g_reg
		for (genvar i = 0; i < NUM_VERTS; i++) begin : g_vert
			for (genvar s = 0; s < NUM_SIDES; s++) begin : g_side
				trc_side_lane #(.COORD_BITS(C)) u_side (
					.clk      (clk),
					.en       (en),
					.edge_vec (edge_vec[r][s]),
					.corner   (corner[r][s]),
					.point_s1 (p_s1[i]),
					.norm_s2  (norm_s2[r]),
					.sign_s5  (sign_s5[r][i][s])
				);
				assign both_flags[(r * NUM_VERTS + i) * NUM_SIDES + s] =
					sign_s5[r][i][s].pos && sign_s5[r][i][s].neg;
			end

			trc_sphere_lane #(.COORD_BITS(C)) u_sphere (
				.clk      (clk),
				.en       (en),
				.point_s1 (p_s1[i]),
				.center   (center[r]),
				.radius   (radius[r]),
				.ok_s5    (ok_s5[r][i])
			);
		end
	end

	trc_merge u_merge (
		.opcode    (op_s5),
		.signs     (sign_s5),
		.sphere_ok (ok_s5),
		.region    (region_next)
	);

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			region_q <= region_next;
		end
	end

	assign result.valid = out_valid_q;
	assign result.region = region_q;

	`TRC_ASSERT_NEXT(a_accept_enters, item.valid && item.ready, v_s1)
	`TRC_ASSERT_IMPL(a_sign_exclusive, v_s5, both_flags == '0)
	`TRC_ASSERT_NEXT(a_stall_holds, v_s5 && !en, v_s5 && out_valid_q)
	`TRC_ASSERT_NEXT(a_drain_to_out, v_s5 && en, out_valid_q)
endmodule
